/* hdl/assert_macros.svh */
// Assertion macros for the checker of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define JSV_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("jsv same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define JSV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("jsv next-cycle check failed");

`endif

/* hdl/jsv_pkg.sv */
// Types, codes and character helpers for the JSON scalar validator.
package jsv_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_EXPECT       = 2'd1;
    localparam logic [1:0] ST_INVALID      = 2'd2;
    localparam logic [1:0] ST_NOT_SINGULAR = 2'd3;

    // Value type codes
    localparam logic [1:0] TY_NULL   = 2'd0;
    localparam logic [1:0] TY_FALSE  = 2'd1;
    localparam logic [1:0] TY_TRUE   = 2'd2;
    localparam logic [1:0] TY_NUMBER = 2'd3;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_LIT,
        PH_MINUS,
        PH_ZERO,
        PH_INT,
        PH_DOT,
        PH_FRAC,
        PH_EXP_MARK,
        PH_EXP_SIGN,
        PH_EXP,
        PH_TRAIL,
        PH_ERROR
    } t_phase;

    // One result word from the scanner
    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic [1:0] vtype;
    } t_result;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[CH_0:CH_9]};
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        return (kind == TY_FALSE) ? 3'd5 : 3'd4;
    endfunction

    // Expected character of a literal at a position; NUL past its end
    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] c;
        c = CH_NUL;
        case (kind)
            TY_NULL: begin
                case (pos)
                    3'd0: c = CH_N;
                    3'd1: c = CH_U;
                    3'd2: c = CH_L;
                    3'd3: c = CH_L;
                    default: c = CH_NUL;
                endcase
            end
            TY_FALSE: begin
                case (pos)
                    3'd0: c = CH_F;
                    3'd1: c = CH_A;
                    3'd2: c = CH_L;
                    3'd3: c = CH_S;
                    3'd4: c = CH_E;
                    default: c = CH_NUL;
                endcase
            end
            TY_TRUE: begin
                case (pos)
                    3'd0: c = CH_T;
                    3'd1: c = CH_R;
                    3'd2: c = CH_U;
                    3'd3: c = CH_E;
                    default: c = CH_NUL;
                endcase
            end
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

/* hdl/json_scalar_validator.sv */
// Top level of the JSON scalar validator: scanner plus output register and skid stage.
//
// The block checks one JSON text, fed one byte per word on the input channel,
// and gives one result word when it takes the zero terminator byte. Leading
// and trailing whitespace (space, tab, CR, LF) are skipped; between them it
// expects exactly one scalar: true, false, null or a JSON number. The result
// carries a status (ok, expect value, invalid value, root not singular) and a
// value type, which reads null on any error. After an error the remaining
// bytes are ignored until the terminator, which reports the first error and
// returns the scanner to its reset state for the next text.
// Rate: one byte per clock cycle while o_stall is low; a byte only advances the scan
// state machine, whose next state is a combinational function of byte compares.
// The result word of a taken terminator is registered into the output register,
// or into the skid stage while the output is stalled. The output register and
// one-word skid stage decouple the two sides: o_stall rises only while the
// skid stage holds a word, that is when two results wait behind a stalled output.
module json_scalar_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_parse_status,
    output logic [1:0] o_value_type
);

    jsv_pkg::t_result scan_res;

    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [1:0]       r_out_type;
    logic             r_skid_valid;
    logic [1:0]       r_skid_status;
    logic [1:0]       r_skid_type;

    logic             in_take;
    logic             out_free;

    // Take a byte whenever the skid stage is empty.
    assign in_take  = i_valid && !r_skid_valid;
    // Output register can load this cycle: empty or being drained.
    assign out_free = !r_out_valid || !i_stall;

    jsv_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_take),
        .i_text_byte (i_text_byte),
        .o_result    (scan_res)
    );

    // Control: output register and skid valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // Drain skid first; no byte is taken while it is full.
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= scan_res.valid;
            end
        end else if (scan_res.valid) begin
            // Output held by a stall: park the new word.
            r_skid_valid <= 1'b1;
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_status <= r_skid_status;
                r_out_type   <= r_skid_type;
            end else begin
                r_out_status <= scan_res.status;
                r_out_type   <= scan_res.vtype;
            end
        end else if (scan_res.valid) begin
            r_skid_status <= scan_res.status;
            r_skid_type   <= scan_res.vtype;
        end
    end

    assign o_stall        = r_skid_valid;
    assign o_valid        = r_out_valid;
    assign o_parse_status = r_out_status;
    assign o_value_type   = r_out_type;

endmodule

/* hdl/jsv_scan.sv */
// Scan state machine: advances one byte per step, reports at the terminator.
module jsv_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_text_byte,
    output jsv_pkg::t_result     o_result
);

    jsv_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_pos, n_pos;
    logic [1:0]      r_kind, n_kind;
    logic [1:0]      r_lstat, n_lstat;

    logic            term;
    logic            lit_bad;
    logic [2:0]      pos_inc;

    assign term    = i_step && (i_text_byte == jsv_pkg::CH_NUL);
    assign pos_inc = r_pos + 3'd1;
    assign lit_bad = (r_kind == jsv_pkg::TY_NUMBER) || (r_pos >= jsv_pkg::lit_len(r_kind))
                     || (jsv_pkg::lit_char(r_kind, r_pos) != i_text_byte);

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_kind  = r_kind;
        n_lstat = r_lstat;
        if (term) begin
            n_phase = jsv_pkg::PH_LEAD;
            n_pos   = 3'd0;
            n_kind  = jsv_pkg::TY_NULL;
            n_lstat = jsv_pkg::ST_OK;
        end else if (i_step) begin
            case (r_phase)
                jsv_pkg::PH_LEAD: begin
                    if (jsv_pkg::is_ws(i_text_byte)) begin
                        n_phase = r_phase;
                    end else if (i_text_byte == jsv_pkg::CH_T) begin
                        n_kind  = jsv_pkg::TY_TRUE;
                        n_pos   = 3'd1;
                        n_phase = jsv_pkg::PH_LIT;
                    end else if (i_text_byte == jsv_pkg::CH_F) begin
                        n_kind  = jsv_pkg::TY_FALSE;
                        n_pos   = 3'd1;
                        n_phase = jsv_pkg::PH_LIT;
                    end else if (i_text_byte == jsv_pkg::CH_N) begin
                        n_kind  = jsv_pkg::TY_NULL;
                        n_pos   = 3'd1;
                        n_phase = jsv_pkg::PH_LIT;
                    end else if (i_text_byte == jsv_pkg::CH_MINUS) begin
                        n_kind  = jsv_pkg::TY_NUMBER;
                        n_phase = jsv_pkg::PH_MINUS;
                    end else begin
                        n_kind = jsv_pkg::TY_NUMBER;
                        if (i_text_byte == jsv_pkg::CH_0) begin
                            n_phase = jsv_pkg::PH_ZERO;
                        end else if (jsv_pkg::is_digit(i_text_byte)) begin
                            n_phase = jsv_pkg::PH_INT;
                        end else begin
                            n_phase = jsv_pkg::PH_ERROR;
                            n_lstat = jsv_pkg::ST_INVALID;
                        end
                    end
                end
                jsv_pkg::PH_LIT: begin
                    if (lit_bad) begin
                        n_phase = jsv_pkg::PH_ERROR;
                        n_lstat = jsv_pkg::ST_INVALID;
                    end else begin
                        n_pos = pos_inc;
                        if (pos_inc == jsv_pkg::lit_len(r_kind)) begin
                            n_phase = jsv_pkg::PH_TRAIL;
                        end
                    end
                end
                jsv_pkg::PH_MINUS: begin
                    n_kind = jsv_pkg::TY_NUMBER;
                    if (i_text_byte == jsv_pkg::CH_0) begin
                        n_phase = jsv_pkg::PH_ZERO;
                    end else if (jsv_pkg::is_digit(i_text_byte)) begin
                        n_phase = jsv_pkg::PH_INT;
                    end else begin
                        n_phase = jsv_pkg::PH_ERROR;
                        n_lstat = jsv_pkg::ST_INVALID;
                    end
                end
                jsv_pkg::PH_ZERO, jsv_pkg::PH_INT, jsv_pkg::PH_FRAC: begin
                    if ((r_phase != jsv_pkg::PH_ZERO) && jsv_pkg::is_digit(i_text_byte)) begin
                        n_phase = r_phase;
                    end else if ((i_text_byte == jsv_pkg::CH_DOT)
                                 && (r_phase != jsv_pkg::PH_FRAC)) begin
                        n_phase = jsv_pkg::PH_DOT;
                    end else if ((i_text_byte == jsv_pkg::CH_E)
                                 || (i_text_byte == jsv_pkg::CH_UP_E)) begin
                        n_phase = jsv_pkg::PH_EXP_MARK;
                    end else if (jsv_pkg::is_ws(i_text_byte)) begin
                        n_phase = jsv_pkg::PH_TRAIL;
                    end else begin
                        n_phase = jsv_pkg::PH_ERROR;
                        n_lstat = jsv_pkg::ST_NOT_SINGULAR;
                    end
                end
                jsv_pkg::PH_DOT: begin
                    if (jsv_pkg::is_digit(i_text_byte)) begin
                        n_phase = jsv_pkg::PH_FRAC;
                    end else begin
                        n_phase = jsv_pkg::PH_ERROR;
                        n_lstat = jsv_pkg::ST_INVALID;
                    end
                end
                jsv_pkg::PH_EXP_MARK: begin
                    if ((i_text_byte == jsv_pkg::CH_PLUS) || (i_text_byte == jsv_pkg::CH_MINUS)) begin
                        n_phase = jsv_pkg::PH_EXP_SIGN;
                    end else if (jsv_pkg::is_digit(i_text_byte)) begin
                        n_phase = jsv_pkg::PH_EXP;
                    end else begin
                        n_phase = jsv_pkg::PH_ERROR;
                        n_lstat = jsv_pkg::ST_INVALID;
                    end
                end
                jsv_pkg::PH_EXP_SIGN: begin
                    if (jsv_pkg::is_digit(i_text_byte)) begin
                        n_phase = jsv_pkg::PH_EXP;
                    end else begin
                        n_phase = jsv_pkg::PH_ERROR;
                        n_lstat = jsv_pkg::ST_INVALID;
                    end
                end
                jsv_pkg::PH_EXP: begin
                    if (jsv_pkg::is_digit(i_text_byte)) begin
                        n_phase = r_phase;
                    end else if (jsv_pkg::is_ws(i_text_byte)) begin
                        n_phase = jsv_pkg::PH_TRAIL;
                    end else begin
                        n_phase = jsv_pkg::PH_ERROR;
                        n_lstat = jsv_pkg::ST_NOT_SINGULAR;
                    end
                end
                jsv_pkg::PH_TRAIL: begin
                    if (!jsv_pkg::is_ws(i_text_byte)) begin
                        n_phase = jsv_pkg::PH_ERROR;
                        n_lstat = jsv_pkg::ST_NOT_SINGULAR;
                    end
                end
                jsv_pkg::PH_ERROR: begin
                    n_phase = r_phase;
                end
                default: begin
                    n_phase = jsv_pkg::PH_ERROR;
                    n_lstat = jsv_pkg::ST_INVALID;
                end
            endcase
        end
    end

    // Result word at the terminator
    always_comb begin
        o_result.valid  = term;
        o_result.vtype  = jsv_pkg::TY_NULL;
        case (r_phase)
            jsv_pkg::PH_LEAD: begin
                o_result.status = jsv_pkg::ST_EXPECT;
            end
            jsv_pkg::PH_ZERO, jsv_pkg::PH_INT, jsv_pkg::PH_FRAC,
            jsv_pkg::PH_EXP, jsv_pkg::PH_TRAIL: begin
                o_result.status = jsv_pkg::ST_OK;
                o_result.vtype  = r_kind;
            end
            jsv_pkg::PH_ERROR: begin
                o_result.status = r_lstat;
            end
            default: begin
                o_result.status = jsv_pkg::ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jsv_pkg::PH_LEAD;
            r_pos   <= 3'd0;
            r_kind  <= jsv_pkg::TY_NULL;
            r_lstat <= jsv_pkg::ST_OK;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_kind  <= n_kind;
            r_lstat <= n_lstat;
        end
    end

endmodule

/* hdl/jsv_checker.sv */
// Port-level checker for the JSON scalar validator, bound to the top level.
`include "assert_macros.svh"

module jsv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_text_byte,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_parse_status,
    input logic [1:0] o_value_type
);

    // A stalled result word holds.
    `JSV_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_parse_status) && $stable(o_value_type))

    // The input side only stalls when a result is waiting at the output.
    `JSV_ASSERT_SAME(a_stall_needs_out, o_stall, o_valid)

    // A terminator taken with the output empty shows up the next cycle.
    `JSV_ASSERT_NEXT(a_term_to_out, i_valid && !o_stall && (i_text_byte == jsv_pkg::CH_NUL) && !o_valid, o_valid)

    // Errors always report a null type.
    `JSV_ASSERT_SAME(a_err_null_type, o_valid, (o_parse_status == jsv_pkg::ST_OK) || (o_value_type == jsv_pkg::TY_NULL))

endmodule

bind json_scalar_validator jsv_checker u_jsv_checker (.*);
